// ===== sv/jss_pkg.sv =====
`timescale 1ns / 1ps

package jss_pkg;

   // Fixed field widths.
   localparam int KEY_W   = 32;
   localparam int TADDR_W = 10;
   localparam int COUNT_W = 11;
   localparam int STEP_W  = 6;
   localparam int IDX_W   = 12;   // holds the block end, which may run past the entry count
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   // Request commands.
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_ENTRY_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_JUMP_STEP   = 1'b1;

   typedef logic signed [KEY_W-1:0] key_type;

   typedef struct packed {
      logic [COUNT_W-1:0] entry_count;
      logic [STEP_W-1:0]  jump_step;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic               found;
      logic [TADDR_W-1:0] position;
   } res_type;

endpackage

// ===== sv/jss_key_mem.sv =====
`timescale 1ns / 1ps

module jss_key_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  jss_pkg::key_type wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output jss_pkg::key_type rd_data
);
   import jss_pkg::*;

   key_type mem_ff [DEPTH];
   key_type rd_data_ff;

   // Contents are undefined until software loads them.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/jss_search_fsm.sv =====
`timescale 1ns / 1ps

module jss_search_fsm #(
   parameter int TABLE_DEPTH = 1024,
   parameter int AW          = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  jss_pkg::key_type target,
   input  jss_pkg::cfg_type cfg,
   input  jss_pkg::key_type rd_data,
   input  logic             out_free,
   output logic             busy,
   output logic             rd_en,
   output logic [AW-1:0]    rd_addr,
   output jss_pkg::res_type res
);
   import jss_pkg::*;

   localparam logic [COUNT_W-1:0] N_CAP =
      COUNT_W'((TABLE_DEPTH < 2047) ? TABLE_DEPTH : 2047);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_JUMP = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   lo_ff, lo_in;
   logic [IDX_W-1:0]   hi_ff, hi_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic [STEP_W-1:0]  s_ff, s_in;
   key_type            target_ff, target_in;
   logic               found_ff, found_in;
   logic [TADDR_W-1:0] pos_ff, pos_in;

   logic [COUNT_W-1:0] n_start;
   logic [STEP_W-1:0]  s_start;
   logic [IDX_W-1:0]   hi_next;
   logic [IDX_W-1:0]   lo_next;
   logic [IDX_W-1:0]   blk_end;
   logic [IDX_W-1:0]   rd_idx;

   always_comb begin
      n_start = cfg.entry_count;
      if (cfg.entry_count == '0) begin
         n_start = COUNT_W'(1);
      end else if (cfg.entry_count > N_CAP) begin
         n_start = N_CAP;
      end
      s_start = (cfg.jump_step == '0) ? STEP_W'(1) : cfg.jump_step;
   end

   assign hi_next = hi_ff + IDX_W'(s_ff);
   assign lo_next = lo_ff + IDX_W'(1);
   assign blk_end = (hi_ff < IDX_W'(n_ff)) ? hi_ff : IDX_W'(n_ff);

   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      n_in      = n_ff;
      s_in      = s_ff;
      target_in = target_ff;
      found_in  = found_ff;
      pos_in    = pos_ff;
      rd_en     = 1'b0;
      rd_idx    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in      = n_start;
               s_in      = s_start;
               target_in = target;
               lo_in     = '0;
               hi_in     = IDX_W'(s_start);
               rd_en     = 1'b1;
               rd_idx    = ((IDX_W'(s_start) < IDX_W'(n_start)) ?
                            IDX_W'(s_start) : IDX_W'(n_start)) - IDX_W'(1);
               state_in  = ST_JUMP;
            end
         end
         ST_JUMP: begin
            // rd_data holds the last key of the block [lo, hi).
            if (rd_data < target_ff) begin
               lo_in = hi_ff;
               hi_in = hi_next;
               if (hi_ff >= IDX_W'(n_ff)) begin
                  found_in = 1'b0;
                  pos_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  rd_en  = 1'b1;
                  rd_idx = ((hi_next < IDX_W'(n_ff)) ? hi_next : IDX_W'(n_ff))
                           - IDX_W'(1);
               end
            end else begin
               rd_en    = 1'b1;
               rd_idx   = lo_ff;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_data < target_ff) begin
               lo_in = lo_next;
               if (lo_next == blk_end) begin
                  found_in = 1'b0;
                  pos_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  rd_en  = 1'b1;
                  rd_idx = lo_next;
               end
            end else begin
               found_in = (rd_data == target_ff);
               pos_in   = (rd_data == target_ff) ? lo_ff[TADDR_W-1:0] : '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      n_ff      <= n_in;
      s_ff      <= s_in;
      target_ff <= target_in;
      found_ff  <= found_in;
      pos_ff    <= pos_in;
   end

   assign rd_addr      = AW'(rd_idx);
   assign busy         = (state_ff != ST_IDLE);
   assign res.valid    = (state_ff == ST_DONE);
   assign res.found    = found_ff;
   assign res.position = pos_ff;

endmodule

// ===== sv/jump_search_sorted_table.sv =====
`timescale 1ns / 1ps

// Sorted key table with jump search. Software fills the table with signed
// 32-bit keys in ascending order through load requests (command 0), one key
// per request at the given address, and sets entry_count and jump_step
// (normally the floor of the square root of entry_count) through the
// configuration port while the block is idle. A search request (command 1)
// walks the table block by block, reading the last key of each block of
// jump_step entries, then scans the chosen block one entry at a time, and
// returns one response with found and position (position is zero on a miss).
// A load request gives no response. A search request reads one table entry per
// cycle from a single-port-read key memory and occupies the block until its
// response has moved into the output register.
// No new request is taken while a search runs; a finished response waits in
// an output register, so a following load or search can start while the
// previous response is still stalled. Reading a table entry that was never
// loaded gives an undefined key and thus an undefined search outcome.
module jump_search_sorted_table #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel.
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_command,
   input  logic [jss_pkg::TADDR_W-1:0]    req_table_address,
   input  logic signed [jss_pkg::KEY_W-1:0] req_key_value,
   // Response channel.
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_found,
   output logic [jss_pkg::TADDR_W-1:0]    rsp_position,
   // Configuration write port.
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [jss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [jss_pkg::CSR_DATA_W-1:0] csr_data
);
   import jss_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   cfg_type cfg_ff, cfg_in;

   logic               req_accept;
   logic               busy;
   logic               mem_we;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   key_type            rd_data;
   res_type            res;
   logic               out_free;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [TADDR_W-1:0] rsp_position_ff, rsp_position_in;

   // Configuration registers. Writes must be issued only while idle (the block does
   // not enforce it); the port is always ready, and an index outside the register list is dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ENTRY_COUNT: cfg_in.entry_count = csr_data[COUNT_W-1:0];
            REG_JUMP_STEP:   cfg_in.jump_step   = csr_data[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.entry_count <= COUNT_W'(1);
         cfg_ff.jump_step   <= STEP_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Requests are taken only while no search is running.
   assign req_stall  = busy;
   assign req_accept = req_valid && !req_stall;

   // A load beyond the physical table is dropped.
   assign mem_we = req_accept && (req_command == CMD_LOAD) &&
                   (32'(req_table_address) < 32'(TABLE_DEPTH));

   jss_key_mem #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (AW'(req_table_address)),
      .wr_data (req_key_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   jss_search_fsm #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .AW          (AW)
   ) u_fsm (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept && (req_command == CMD_SEARCH)),
      .target   (req_key_value),
      .cfg      (cfg_ff),
      .rd_data  (rd_data),
      .out_free (out_free),
      .busy     (busy),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .res      (res)
   );

   // Output register. It takes a new response whenever it is empty or its
   // current response leaves in the same cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      if (out_free) begin
         rsp_valid_in    = res.valid;
         rsp_found_in    = res.found;
         rsp_position_in = res.position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

   // A search request keeps the request side stalled in the next cycle.
   a_search_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_command == CMD_SEARCH)) |=> req_stall)
      else $error("search request did not stall the request channel");

   // A miss always reports position zero.
   a_miss_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_position == '0))
      else $error("miss response carries a nonzero position");

   // A response appears only after the search finished.
   a_rsp_from_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(res.valid))
      else $error("response appeared without a finished search");

endmodule

// ===== verif/jump_search_sorted_table_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the jump-search key table. A short stimulus table
// comes first, then random phases that each reprogram the registers, may refill
// the table with ascending keys and search it. Every search response is
// compared field by field with a hand-typed result or with a jump search run
// over a shadow copy of the table in this bench.
module jump_search_sorted_table_tb;

   import jss_pkg::*;

   localparam int TABLE_DEPTH   = 1024;
   localparam int RANDOM_ITEMS  = 600;
   localparam int CYCLE_LIMIT   = 1_000_000;
   // A load has no response, so the block may still be writing it when the
   // last search response has arrived. This many cycles cover that.
   localparam int SETTLE_CYCLES = 4;
   localparam int MAX_PRINTED   = 100;

   localparam key_type KEY_MIN = 32'sh8000_0000;
   localparam key_type KEY_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      logic               found;
      logic [TADDR_W-1:0] position;
   } search_result_type;

   typedef enum logic {
      ROW_CONFIG,
      ROW_REQUEST
   } plan_kind_type;

   // One row of the directed part. Config rows use the register fields, request
   // rows the payload fields. When known is set, the row carries the response
   // typed in by hand; otherwise the shadow search supplies it.
   typedef struct {
      plan_kind_type         kind;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0] reg_data;
      logic                  command;
      logic [TADDR_W-1:0]    address;
      key_type               key;
      bit                    known;
      logic                  found;
      logic [TADDR_W-1:0]    position;
   } plan_row_type;

   localparam int PLAN_ROWS = 27;

   logic                  clock;
   logic                  reset             = 1'b1;
   logic                  req_valid         = 1'b0;
   logic                  req_stall;
   logic                  req_command       = CMD_LOAD;
   logic [TADDR_W-1:0]    req_table_address = '0;
   key_type               req_key_value     = '0;
   logic                  rsp_valid;
   logic                  rsp_stall         = 1'b0;
   logic                  rsp_found;
   logic [TADDR_W-1:0]    rsp_position;
   logic                  csr_valid         = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index         = '0;
   logic [CSR_DATA_W-1:0] csr_data          = '0;

   // Shadow state of the block: table contents, which entries were ever
   // loaded, and the register settings.
   key_type key_shadow [TABLE_DEPTH];
   bit      loaded     [TABLE_DEPTH];
   cfg_type shadow_cfg = '{entry_count: 1, jump_step: 1};

   search_result_type pending_results[$];

   int          error_count    = 0;
   int          load_count     = 0;
   int          search_count   = 0;
   int          hit_count      = 0;
   int          reg_writes     = 0;
   int          send_idle_pct  = 25;
   int          rsp_stall_pct  = 71;
   int unsigned cycle_count    = 0;

   plan_row_type directed_plan [PLAN_ROWS];

   jump_search_sorted_table #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Jump search over the shadow table. The entry count is clamped into 1 to
   // the table depth and a zero step counts as one step; a step larger than the
   // table is used as written. The first loop walks whole blocks by their last
   // key and gives up once the block start has passed the entry count. The
   // second loop scans the chosen block and gives up at the block end.
   function automatic search_result_type locate_key(input key_type target);
      int unsigned       n;
      int unsigned       s;
      int unsigned       hi;
      int unsigned       lo;
      int unsigned       block_end;
      bit                missed;
      search_result_type res;
      n = shadow_cfg.entry_count;
      if (n == 0) n = 1;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      s = shadow_cfg.jump_step;
      if (s == 0) s = 1;
      hi = s;
      lo = 0;
      missed = 1'b0;
      res.found = 1'b0;
      res.position = '0;
      while (key_shadow[((hi < n) ? hi : n) - 1] < target) begin
         lo = hi;
         hi += s;
         if (lo >= n) begin
            missed = 1'b1;
            break;
         end
      end
      if (!missed) begin
         block_end = (hi < n) ? hi : n;
         while (key_shadow[lo] < target) begin
            lo++;
            if (lo == block_end) begin
               missed = 1'b1;
               break;
            end
         end
         if (!missed && key_shadow[lo] == target) begin
            res.found = 1'b1;
            res.position = TADDR_W'(lo);
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      // Only the first mismatches are printed; all of them are counted.
      if (error_count < MAX_PRINTED)
         $display("%0t ns: mismatch: %s", $time, what);
      error_count++;
   endtask

   // Sends one request. The valid line is left high on return, so the next
   // request can follow at once; an idle gap or a drain lowers it.
   task automatic issue_request(input logic command, input logic [TADDR_W-1:0] address,
                                input key_type key, input bit known, input logic exp_found,
                                input logic [TADDR_W-1:0] exp_position);
      search_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= command;
      req_table_address <= address;
      req_key_value     <= key;
      do @(posedge clock); while (req_stall);
      // The request was taken at this edge.
      if (command == CMD_LOAD) begin
         key_shadow[address] = key;
         loaded[address] = 1'b1;
         load_count++;
      end else begin
         if (known) begin
            res.found = exp_found;
            res.position = exp_position;
         end else begin
            res = locate_key(key);
         end
         pending_results.push_back(res);
         search_count++;
         if (res.found) hit_count++;
      end
   endtask

   // Holds the request channel idle until every search has answered, then lets
   // a possible trailing load finish.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes happen only on an idle block.
   task automatic program_register(input logic [CSR_IDX_W-1:0] index,
                                   input logic [CSR_DATA_W-1:0] value);
      drain_pipeline();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == REG_ENTRY_COUNT)
         shadow_cfg.entry_count = value[COUNT_W-1:0];
      else if (index == REG_JUMP_STEP)
         shadow_cfg.jump_step = value[STEP_W-1:0];
      reg_writes++;
   endtask

   // Response side: check each response taken and pick a new stall level for
   // the next cycle. Values are sampled as they stood before the edge.
   always @(posedge clock) begin
      search_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response found=%0b position=%0d with no search pending",
                                      rsp_found, rsp_position));
         end else begin
            want = pending_results.pop_front();
            if (rsp_found !== want.found)
               report_mismatch($sformatf("found is %b, expected %b", rsp_found, want.found));
            if (rsp_position !== want.position)
               report_mismatch($sformatf("position is %0d, expected %0d",
                                         rsp_position, want.position));
         end
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, pending_results.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      int          row;
      int          phase;
      int          random_items;
      int          raw_count;
      int          n_eff;
      int          step_val;
      int          searches;
      int          idx;
      int          inc_max;
      bit          reload;
      bit          descending;
      longint      next_key;
      key_type     target;
      key_type     fill_keys [TABLE_DEPTH];

      // Directed part. The table starts as min key, -5, 0, max key; the last
      // address is also loaded once to reach the top of the address range.
      directed_plan = '{
         '{ROW_REQUEST, REG_ENTRY_COUNT, 11'd0, CMD_LOAD, 10'd0, KEY_MIN, 1'b0, 1'b0, 10'd0},
         // Reset settings search a one-entry table.
         '{ROW_REQUEST, REG_ENTRY_COUNT, 11'd0, CMD_SEARCH, 10'd0, KEY_MIN, 1'b1, 1'b1, 10'd0},
         '{ROW_REQUEST, REG_ENTRY_COUNT, 11'd0, CMD_SEARCH, 10'd0, 32'sd5, 1'b1, 1'b0, 10'd0},
         '{ROW_REQUEST, REG_ENTRY_COUNT, 11'd0, CMD_LOAD, 10'd1023, KEY_MAX, 1'b0, 1'b0, 10'd0},
         '{ROW_REQUEST, REG_ENTRY_COUNT, 11'd0, CMD_LOAD, 10'd1, -32'sd5, 1'b0, 1'b0, 10'd0},
         '{ROW_REQUEST, REG_ENTRY_COUNT, 11'd0, CMD_LOAD, 10'd2, 32'sd0, 1'b0, 1'b0, 10'd0},
         '{ROW_REQUEST, REG_ENTRY_COUNT, 11'd0, CMD_LOAD, 10'd3, KEY_MAX, 1'b0, 1'b0, 10'd0},
         '{ROW_CONFIG, REG_ENTRY_COUNT, 11'd4, CMD_LOAD, 10'd0, 32'sd0, 1'b0, 1'b0, 10'd0},
         '{ROW_CONFIG, REG_JUMP_STEP, 11'd2, CMD_LOAD, 10'd0, 32'sd0, 1'b0, 1'b0, 10'd0},
         // Hits at both ends of the table, one miss between keys, a hit inside.
         '{ROW_REQUEST, REG_ENTRY_COUNT, 11'd0, CMD_SEARCH, 10'd0, KEY_MIN, 1'b1, 1'b1, 10'd0},
         '{ROW_REQUEST, REG_ENTRY_COUNT, 11'd0, CMD_SEARCH, 10'd0, KEY_MAX, 1'b1, 1'b1, 10'd3},
         '{ROW_REQUEST, REG_ENTRY_COUNT, 11'd0, CMD_SEARCH, 10'd5, 32'sd1, 1'b1, 1'b0, 10'd0},
         '{ROW_REQUEST, REG_ENTRY_COUNT, 11'd0, CMD_SEARCH, 10'd9, -32'sd5, 1'b1, 1'b1, 10'd1},
         // A zero entry count and a zero step both act as one.
         '{ROW_CONFIG, REG_ENTRY_COUNT, 11'd0, CMD_LOAD, 10'd0, 32'sd0, 1'b0, 1'b0, 10'd0},
         '{ROW_CONFIG, REG_JUMP_STEP, 11'd0, CMD_LOAD, 10'd0, 32'sd0, 1'b0, 1'b0, 10'd0},
         '{ROW_REQUEST, REG_ENTRY_COUNT, 11'd0, CMD_SEARCH, 10'd0, KEY_MIN, 1'b1, 1'b1, 10'd0},
         '{ROW_REQUEST, REG_ENTRY_COUNT, 11'd0, CMD_SEARCH, 10'd0, -32'sd5, 1'b1, 1'b0, 10'd0},
         // A step far larger than the table goes straight to the linear scan.
         '{ROW_CONFIG, REG_ENTRY_COUNT, 11'd4, CMD_LOAD, 10'd0, 32'sd0, 1'b0, 1'b0, 10'd0},
         '{ROW_CONFIG, REG_JUMP_STEP, 11'd63, CMD_LOAD, 10'd0, 32'sd0, 1'b0, 1'b0, 10'd0},
         '{ROW_REQUEST, REG_ENTRY_COUNT, 11'd0, CMD_SEARCH, 10'd0, 32'sd0, 1'b0, 1'b0, 10'd0},
         // Target above every key: the block walk runs off the table end.
         '{ROW_CONFIG, REG_ENTRY_COUNT, 11'd3, CMD_LOAD, 10'd0, 32'sd0, 1'b0, 1'b0, 10'd0},
         '{ROW_CONFIG, REG_JUMP_STEP, 11'd1, CMD_LOAD, 10'd0, 32'sd0, 1'b0, 1'b0, 10'd0},
         '{ROW_REQUEST, REG_ENTRY_COUNT, 11'd0, CMD_SEARCH, 10'd0, 32'sd7, 1'b1, 1'b0, 10'd0},
         // Break the ordering and search the misplaced key.
         '{ROW_REQUEST, REG_ENTRY_COUNT, 11'd0, CMD_LOAD, 10'd2, -32'sd100, 1'b0, 1'b0, 10'd0},
         '{ROW_CONFIG, REG_ENTRY_COUNT, 11'd4, CMD_LOAD, 10'd0, 32'sd0, 1'b0, 1'b0, 10'd0},
         '{ROW_CONFIG, REG_JUMP_STEP, 11'd2, CMD_LOAD, 10'd0, 32'sd0, 1'b0, 1'b0, 10'd0},
         '{ROW_REQUEST, REG_ENTRY_COUNT, 11'd0, CMD_SEARCH, 10'd0, -32'sd100, 1'b0, 1'b0, 10'd0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[r]) begin
         if (directed_plan[r].kind == ROW_CONFIG)
            program_register(directed_plan[r].reg_index, directed_plan[r].reg_data);
         else
            issue_request(directed_plan[r].command, directed_plan[r].address,
                          directed_plan[r].key, directed_plan[r].known,
                          directed_plan[r].found, directed_plan[r].position);
      end

      // Random phases. The first programs an entry count beyond the depth with
      // a step of 32 and loads only the entries that reach the top of the
      // table: the first block, every block end for steps of 32 and 63, and
      // the last block. The second keeps that table with the largest step.
      // Searches in these two phases pick targets whose walk stays on loaded
      // entries. The rest mostly use small tables, where searches are cheap.
      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         // Flow control: sender idles a quarter of the time while the response
         // side stalls most cycles, then the reverse, then no idling at all.
         case (random_items * 3 / RANDOM_ITEMS)
            0: begin
               send_idle_pct = 25;
               rsp_stall_pct = 71;
            end
            1: begin
               send_idle_pct = 71;
               rsp_stall_pct = 25;
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase

         if (phase == 0) begin
            raw_count = 2047;
            step_val = 32;
         end else if (phase == 1) begin
            raw_count = 1024;
            step_val = 63;
         end else begin
            case ($urandom_range(9))
               0: raw_count = 0;
               1: raw_count = $urandom_range(1, 200);
               default: raw_count = $urandom_range(1, 40);
            endcase
            n_eff = (raw_count == 0) ? 1 : raw_count;
            if ($urandom_range(4) == 0) begin
               step_val = $urandom_range(0, 63);
            end else begin
               step_val = 1;
               while ((step_val + 1) * (step_val + 1) <= n_eff) step_val++;
            end
         end
         n_eff = (raw_count == 0) ? 1 : ((raw_count > TABLE_DEPTH) ? TABLE_DEPTH : raw_count);

         if ($urandom_range(1)) begin
            program_register(REG_ENTRY_COUNT, CSR_DATA_W'(raw_count));
            program_register(REG_JUMP_STEP, CSR_DATA_W'(step_val));
         end else begin
            program_register(REG_JUMP_STEP, CSR_DATA_W'(step_val));
            program_register(REG_ENTRY_COUNT, CSR_DATA_W'(raw_count));
         end

         // A search must never read an entry that was never loaded, so refill
         // whenever a small searched range has a hole. The second phase reuses
         // the sparse table of the first.
         reload = (phase == 0) || (phase > 1 && $urandom_range(3) != 0);
         if (phase > 1)
            for (idx = 0; idx < n_eff; idx++)
               if (!loaded[idx]) reload = 1'b1;

         if (reload) begin
            // Ascending keys, clamped at the top key. Small increments give
            // duplicates and near neighbours, large ones spread the range.
            // The first phase uses strictly rising keys that stay below the
            // top key.
            if (phase == 0) begin
               next_key = KEY_MIN;
               inc_max = 1 << 21;
            end else begin
               next_key = $signed($urandom);
               case ($urandom_range(3))
                  0: inc_max = 2;
                  1: inc_max = 40;
                  2: inc_max = 1 << 20;
                  default: inc_max = 1 << 26;
               endcase
            end
            for (idx = 0; idx < n_eff; idx++) begin
               fill_keys[idx] = (next_key > KEY_MAX) ? KEY_MAX : key_type'(next_key[31:0]);
               next_key += $urandom_range((phase == 0) ? 1 : 0, inc_max);
            end
            descending = $urandom_range(1);
            for (idx = 0; idx < n_eff; idx++) begin
               row = descending ? (n_eff - 1 - idx) : idx;
               // The full-range table loads only what its searches can reach.
               if (phase == 0 && row >= 63 && row < 992 && (row % 32) != 31 &&
                   (row % 63) != 62)
                  continue;
               issue_request(CMD_LOAD, TADDR_W'(row), fill_keys[row], 1'b0, 1'b0, '0);
               random_items++;
            end
         end

         searches = (phase < 2) ? 25 : $urandom_range(8, 30);
         for (idx = 0; idx < searches; idx++) begin
            // Now and then a stray load lands anywhere, which may unsort the
            // searched range.
            if (phase > 1 && $urandom_range(11) == 0) begin
               issue_request(CMD_LOAD, TADDR_W'($urandom_range(0, TABLE_DEPTH - 1)),
                             $urandom, 1'b0, 1'b0, '0);
               random_items++;
            end
            if (phase < 2) begin
               // Keys of the first block or one above them, keys of the last block, the
               // extreme keys, or a target beyond the last key, which walks off the table end.
               case ($urandom_range(5))
                  0, 1: target = key_shadow[$urandom_range(0, 30)];
                  2: target = key_shadow[$urandom_range(0, 30)] + 1;
                  3: target = key_shadow[$urandom_range(1008, 1023)];
                  4: target = key_shadow[1023] + 1;
                  default: target = $urandom_range(1) ? KEY_MAX : KEY_MIN;
               endcase
            end else begin
               case ($urandom_range(9))
                  0, 1, 2, 3, 4: target = key_shadow[$urandom_range(0, n_eff - 1)];
                  5: target = key_shadow[$urandom_range(0, n_eff - 1)] + 1;
                  6: target = key_shadow[$urandom_range(0, n_eff - 1)] - 1;
                  7: target = $urandom_range(1) ? KEY_MAX : KEY_MIN;
                  default: target = $urandom;
               endcase
            end
            issue_request(CMD_SEARCH, TADDR_W'($urandom), target, 1'b0, 1'b0, '0);
            random_items++;
            // Occasionally hold off the sender until every search has answered.
            if ($urandom_range(49) == 0) drain_pipeline();
         end
         phase++;
      end

      drain_pipeline();
      repeat (20) @(posedge clock);

      $display("Ran %0d loads and %0d searches (%0d hits, %0d misses) with %0d register writes,",
               load_count, search_count, hit_count, search_count - hit_count, reg_writes);
      $display("over %0d setting phases, the full address range, unsorted tables and three flow patterns.",
               phase);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
